[rtl/lsbp_pkg.sv]
package lsbp_pkg;

  localparam int unsigned ReqTypeW   = 2;
  localparam int unsigned BitValueW  = 25;
  localparam int unsigned BitCountW  = 5;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned PendW      = 7;
  localparam int unsigned PendCountW = 3;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [ReqTypeW-1:0] {
    REQ_PUT_BITS = 2'd0,
    REQ_PUT_BYTE = 2'd1,
    REQ_FLUSH    = 2'd2
  } req_type_e;

endpackage

[rtl/lsbp_req_if.sv]
interface lsbp_req_if;
  logic                               valid;
  logic                               ready;
  logic [lsbp_pkg::ReqTypeW-1:0]      req_type;
  logic [lsbp_pkg::BitValueW-1:0]     bit_value;
  logic [lsbp_pkg::BitCountW-1:0]     bit_count;
  logic [lsbp_pkg::ByteW-1:0]         byte_value;

  modport source (output valid, output req_type, output bit_value, output bit_count,
                  output byte_value, input ready);
  modport sink (input valid, input req_type, input bit_value, input bit_count,
                input byte_value, output ready);
endinterface

[rtl/lsbp_byte_if.sv]
interface lsbp_byte_if;
  logic                       valid;
  logic                       ready;
  logic [lsbp_pkg::ByteW-1:0] out_byte;
  logic                       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

[rtl/lsbp_front.sv]
module lsbp_front #(
  parameter int unsigned CNT_SAT = 25,
  parameter int unsigned JOB_W   = 32,
  parameter int unsigned NB_W    = 3
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             req_valid_i,
  output logic                             req_ready_o,
  input  logic [lsbp_pkg::ReqTypeW-1:0]    req_type_i,
  input  logic [lsbp_pkg::BitValueW-1:0]   bit_value_i,
  input  logic [lsbp_pkg::BitCountW-1:0]   bit_count_i,
  input  logic [lsbp_pkg::ByteW-1:0]       byte_value_i,
  input  logic                             q_full_i,
  output logic                             push_o,
  output logic [JOB_W-1:0]                 job_acc_o,
  output logic [NB_W-1:0]                  job_nb_o
);

  localparam logic [lsbp_pkg::BitCountW-1:0] CntSat = CNT_SAT[lsbp_pkg::BitCountW-1:0];
  localparam int unsigned TotW = lsbp_pkg::BitCountW + 1;

  logic [lsbp_pkg::PendW-1:0]      pend_q, pend_d;
  logic [lsbp_pkg::PendCountW-1:0] pcnt_q, pcnt_d;
  logic [lsbp_pkg::BitCountW-1:0]  cnt_eff;
  logic [lsbp_pkg::BitValueW-1:0]  val_m;
  logic [JOB_W-1:0]                bits_acc, bits_rest;
  logic [TotW-1:0]                 total;
  logic                            accept;

  assign req_ready_o = !q_full_i;
  assign accept      = req_valid_i && !q_full_i;

  assign cnt_eff   = (bit_count_i > CntSat) ? CntSat : bit_count_i;
  assign val_m     = bit_value_i & ~({lsbp_pkg::BitValueW{1'b1}} << cnt_eff);
  assign bits_acc  = JOB_W'(pend_q) | (JOB_W'(val_m) << pcnt_q);
  assign total     = TotW'(pcnt_q) + TotW'(cnt_eff);
  assign bits_rest = bits_acc >> {total[TotW-1:3], 3'b000};

  always_comb begin
    pend_d    = pend_q;
    pcnt_d    = pcnt_q;
    job_acc_o = '0;
    job_nb_o  = '0;
    case (lsbp_pkg::req_type_e'(req_type_i))
      lsbp_pkg::REQ_PUT_BITS: begin
        job_acc_o = bits_acc;
        job_nb_o  = NB_W'(total[TotW-1:3]);
        pend_d    = bits_rest[lsbp_pkg::PendW-1:0];
        pcnt_d    = total[2:0];
      end
      lsbp_pkg::REQ_PUT_BYTE: begin
        if (pcnt_q != '0) begin
          job_acc_o = JOB_W'({byte_value_i, 1'b0, pend_q});
          job_nb_o  = NB_W'(2);
        end else begin
          job_acc_o = JOB_W'(byte_value_i);
          job_nb_o  = NB_W'(1);
        end
        pend_d = '0;
        pcnt_d = '0;
      end
      lsbp_pkg::REQ_FLUSH: begin
        job_acc_o = JOB_W'(pend_q);
        job_nb_o  = NB_W'(pcnt_q != '0);
        pend_d    = '0;
        pcnt_d    = '0;
      end
      default: begin
        job_nb_o = '0;
      end
    endcase
  end

  assign push_o = accept && (job_nb_o != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      pcnt_q <= '0;
    end else if (accept) begin
      pend_q <= pend_d;
      pcnt_q <= pcnt_d;
    end
  end

endmodule

[rtl/lsbp_queue.sv]
module lsbp_queue #(
  parameter int unsigned WIDTH = 35
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0]                   mem_q [lsbp_pkg::QueueDepth];
  logic [lsbp_pkg::QueuePtrW-1:0]     wptr_q, rptr_q;
  logic [lsbp_pkg::QueueCntW-1:0]     cnt_q;
  logic                               do_push, do_pop;

  assign full_o     = (cnt_q == lsbp_pkg::QueueCntW'(lsbp_pkg::QueueDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[rtl/lsbp_back.sv]
module lsbp_back #(
  parameter int unsigned JOB_W = 32,
  parameter int unsigned NB_W  = 3
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  logic [JOB_W-1:0]           q_acc_i,
  input  logic [NB_W-1:0]            q_nb_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [lsbp_pkg::ByteW-1:0] out_byte_o,
  output logic                       last_of_run_o
);

  logic                       job_valid_q;
  logic [JOB_W-1:0]           acc_q;
  logic [NB_W-1:0]            rem_q;
  logic                       out_valid_q;
  logic [lsbp_pkg::ByteW-1:0] out_byte_q;
  logic                       out_last_q;
  logic                       adv, is_last, finish, load;

  assign adv     = job_valid_q && (!out_valid_q || out_ready_i);
  assign is_last = (rem_q == NB_W'(1));
  assign finish  = adv && is_last;
  assign load    = q_valid_i && (!job_valid_q || finish);
  assign q_pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        job_valid_q <= 1'b1;
      end else if (finish) begin
        job_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      acc_q <= q_acc_i;
      rem_q <= q_nb_i;
    end else if (adv) begin
      acc_q <= acc_q >> lsbp_pkg::ByteW;
      rem_q <= rem_q - 1'b1;
    end
    if (adv) begin
      out_byte_q <= acc_q[lsbp_pkg::ByteW-1:0];
      out_last_q <= is_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = out_last_q;

endmodule

[rtl/lsb_first_bit_packer_core.sv]
// lsb-first bit packer
// req_i carries requests: put bits (0 to MAX_FIELD_BITS bits of bit_value, count
// saturated, bits above the count ignored), put byte (zero pads any partial byte,
// then emits byte_value) and flush (pads and emits a partial byte, if any).
// byte_o carries the packed bytes, earliest bit in bit 0, one byte per transfer;
// last_of_run marks the final byte that a request produces. Requests that complete
// no byte produce nothing on byte_o.
// path: a request's first byte goes through the queue, job and output registers.
// throughput: the front takes one request per cycle while the queue is not full;
// the back emits one byte per cycle while byte_o is ready, and a request yields
// up to 4 bytes at the default setting. A two-entry queue sits between the front,
// which keeps the partial byte, and the back, which shifts out a job register.
// reset: clears the partial byte, the queue and the output; req_i.ready is high
// right after reset.
// a stalled byte_o holds its byte; the back stops, the queue fills, and
// req_i.ready drops only when the queue is full.
module lsb_first_bit_packer_core #(
  parameter int unsigned MAX_FIELD_BITS = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lsbp_req_if.sink    req_i,
  lsbp_byte_if.source byte_o
);

  localparam int unsigned CntMax   = (MAX_FIELD_BITS < 31) ? MAX_FIELD_BITS : 31;
  localparam int unsigned ValBits  = (CntMax < lsbp_pkg::BitValueW) ? CntMax
                                                                     : lsbp_pkg::BitValueW;
  localparam int unsigned AccW     = lsbp_pkg::PendW + ValBits;
  localparam int unsigned MaxBytes = ((AccW / 8) > 2) ? (AccW / 8) : 2;
  localparam int unsigned JobW     = (AccW > 16) ? AccW : 16;
  localparam int unsigned NbW      = $clog2(MaxBytes + 1);

  logic              push, q_full, q_valid, q_pop;
  logic [JobW-1:0]   job_acc, q_acc;
  logic [NbW-1:0]    job_nb, q_nb;

  lsbp_front #(
    .CNT_SAT(CntMax),
    .JOB_W  (JobW),
    .NB_W   (NbW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_type_i  (req_i.req_type),
    .bit_value_i (req_i.bit_value),
    .bit_count_i (req_i.bit_count),
    .byte_value_i(req_i.byte_value),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_acc_o   (job_acc),
    .job_nb_o    (job_nb)
  );

  lsbp_queue #(
    .WIDTH(JobW + NbW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i({job_nb, job_acc}),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_data_o ({q_nb, q_acc})
  );

  lsbp_back #(
    .JOB_W(JobW),
    .NB_W (NbW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_acc_i      (q_acc),
    .q_nb_i       (q_nb),
    .q_pop_o      (q_pop),
    .out_valid_o  (byte_o.valid),
    .out_ready_i  (byte_o.ready),
    .out_byte_o   (byte_o.out_byte),
    .last_of_run_o(byte_o.last_of_run)
  );

endmodule

[rtl/lsbp_checker.sv]
module lsbp_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [lsbp_pkg::ByteW-1:0] out_byte_i,
  input logic                       out_last_i
);

  // output quiet while reset is held
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("byte output valid during reset");

  // stalled byte keeps its payload
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(out_last_i))
    else $error("stalled byte changed");

  // a full queue only arises behind a busy output
  a_full_needs_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_ready_i |-> out_valid_i)
    else $error("request side stalled with nothing on the output");

endmodule

bind lsb_first_bit_packer_core lsbp_checker u_lsbp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .req_ready_i(req_i.ready),
  .out_valid_i(byte_o.valid),
  .out_ready_i(byte_o.ready),
  .out_byte_i (byte_o.out_byte),
  .out_last_i (byte_o.last_of_run)
);
